// File: rtl/fbde_pkg.sv
// ----------------------------------------------------------------------------
// fbde_pkg: shared types and codes of the frame buffer draw engine
// Holds the command codes, register indexes, item and result structs and the
// control and status groups that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package fbde_pkg;

  // Field widths fixed by the command format.
  localparam int ACTION_W = 2;
  localparam int COORD_W  = 9;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = COLOR_W;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_RECT    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_IMAGE   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 2'd2;

  // One accepted command.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COORD_W-1:0]  start_row;
    logic [COORD_W-1:0]  start_col;
    logic [COORD_W-1:0]  end_row;
    logic [COORD_W-1:0]  end_col;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic                filled;
    logic                mask;
  } fbde_item_t;

  // One result.
  typedef struct packed {
    logic [CHAN_W-1:0] read_red;
    logic [CHAN_W-1:0] read_green;
    logic [CHAN_W-1:0] read_blue;
    logic              status;
  } fbde_result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;   // write zero at the sweep address and advance it
    logic load;    // an input transfer takes place this cycle
    logic issue;   // send the current pixel operation down the pipe
  } fbde_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;   // the sweep is at the last frame store entry
    logic op_last;      // the current pixel operation ends the command
    logic result_push;  // a result enters the output queue this cycle
    logic queue_full;   // the output queue has no room for another result
  } fbde_stat_t;

endpackage

// File: rtl/fbde_in_if.sv
// ----------------------------------------------------------------------------
// fbde_in_if: command channel of the frame buffer draw engine
// Valid/ready channel that carries one drawing or read command per transfer.
// ----------------------------------------------------------------------------
interface fbde_in_if;
  import fbde_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  start_row;
  logic [COORD_W-1:0]  start_col;
  logic [COORD_W-1:0]  end_row;
  logic [COORD_W-1:0]  end_col;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic                filled;
  logic                mask;

  modport source (
    output valid, action, start_row, start_col, end_row, end_col,
           red, green, blue, filled, mask,
    input  ready
  );

  modport sink (
    input  valid, action, start_row, start_col, end_row, end_col,
           red, green, blue, filled, mask,
    output ready
  );
endinterface

// File: rtl/fbde_out_if.sv
// ----------------------------------------------------------------------------
// fbde_out_if: result channel of the frame buffer draw engine
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface fbde_out_if;
  import fbde_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] read_red;
  logic [CHAN_W-1:0] read_green;
  logic [CHAN_W-1:0] read_blue;
  logic              status;

  modport source (
    output valid, read_red, read_green, read_blue, status,
    input  ready
  );

  modport sink (
    input  valid, read_red, read_green, read_blue, status,
    output ready
  );
endinterface

// File: rtl/frame_buffer_draw_engine.sv
// ----------------------------------------------------------------------------
// frame_buffer_draw_engine: rectangle fill and color key blitter
// Top level: joins the controller and the datapath to the command, result
// and configuration ports.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on in_ch and each produces exactly one result on out_ch.
//   A rectangle issues one pixel operation per cycle over the pixels it
//   addresses (the whole area when filled, only the border otherwise); every
//   other command, and an empty rectangle, issues a single operation.
//   A command's operations pass through the row product stage and the
//   registered frame store read before its result enters the output queue;
//   in_ch.ready stays low from its input transfer until that push.
//   Results wait in a two-entry queue, so a stalled receiver holds one result
//   while the next command is taken; once two results wait, in_ch.ready
//   stays low until the receiver takes one.
//   After reset the frame store is swept to black, one entry a cycle, over
//   all MAX_COLS * MAX_ROWS entries (65536 at the defaults); in_ch.ready is
//   low during the sweep. Configuration writes on cfg_we are taken at any time
//   and are to be made only while no command is in flight.
// ----------------------------------------------------------------------------
module frame_buffer_draw_engine #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fbde_in_if.sink                          in_ch,
  fbde_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fbde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbde_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fbde_pkg::*;

  fbde_cmd_t    cmd;
  fbde_stat_t   stat;
  fbde_item_t   item;
  fbde_result_t result;
  logic         in_ready;
  logic         out_valid;

  // Gather the command fields into one item.
  always_comb begin
    item.action    = in_ch.action;
    item.start_row = in_ch.start_row;
    item.start_col = in_ch.start_col;
    item.end_row   = in_ch.end_row;
    item.end_col   = in_ch.end_col;
    item.red       = in_ch.red;
    item.green     = in_ch.green;
    item.blue      = in_ch.blue;
    item.filled    = in_ch.filled;
    item.mask      = in_ch.mask;
  end

  fbde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbde_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .result    (result)
  );

  // Drive the channel handshakes and the result fields.
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.read_red   = result.read_red;
  assign out_ch.read_green = result.read_green;
  assign out_ch.read_blue  = result.read_blue;
  assign out_ch.status     = result.status;

endmodule

// File: rtl/fbde_ram.sv
// ----------------------------------------------------------------------------
// fbde_ram: generic single-port RAM with registered read
// One access per cycle; a write stores wdata, and rdata shows the addressed
// entry in the next cycle.
// ----------------------------------------------------------------------------
module fbde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/fbde_ctrl.sv
// ----------------------------------------------------------------------------
// fbde_ctrl: controller of the frame buffer draw engine
// Sequences the clearing sweep after reset, the acceptance of a command, the
// issue of its pixel operations and the wait for its result.
// ----------------------------------------------------------------------------
module fbde_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fbde_pkg::fbde_stat_t   stat,
  output fbde_pkg::fbde_cmd_t    cmd
);
  import fbde_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !stat.queue_full;
        if (in_valid && !stat.queue_full) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.op_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.result_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/fbde_datapath.sv
// ----------------------------------------------------------------------------
// fbde_datapath: datapath of the frame buffer draw engine
// Holds the configuration, the rectangle walker, a two-stage address pipe
// into the frame store, status collection and a two-entry result queue.
// ----------------------------------------------------------------------------
module fbde_datapath #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbde_pkg::fbde_cmd_t                 cmd,
  output fbde_pkg::fbde_stat_t                stat,
  input  fbde_pkg::fbde_item_t                item,
  input  logic                                cfg_we,
  input  logic [fbde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbde_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fbde_pkg::fbde_result_t              result
);
  import fbde_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int COL_CAP = (MAX_COLS < COORD_MAX) ? MAX_COLS : COORD_MAX;
  localparam int ROW_CAP = (MAX_ROWS < COORD_MAX) ? MAX_ROWS : COORD_MAX;
  localparam int COL_RST = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int ROW_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int POS_W   = COORD_W + 1;
  localparam int BASE_W  = 2 * COORD_W;
  localparam int SUM_W   = BASE_W + 1;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration, kept as effective (saturated) sizes.
  logic [COORD_W-1:0] eff_w_r;
  logic [COORD_W-1:0] eff_h_r;
  logic [COLOR_W-1:0] key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= COORD_W'(COL_RST);
      eff_h_r <= COORD_W'(ROW_RST);
      key_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_data[COORD_W-1:0] == '0) begin
            eff_w_r <= COORD_W'(1);
          end else if (int'(cfg_data[COORD_W-1:0]) > COL_CAP) begin
            eff_w_r <= COORD_W'(COL_CAP);
          end else begin
            eff_w_r <= cfg_data[COORD_W-1:0];
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data[COORD_W-1:0] == '0) begin
            eff_h_r <= COORD_W'(1);
          end else if (int'(cfg_data[COORD_W-1:0]) > ROW_CAP) begin
            eff_h_r <= COORD_W'(ROW_CAP);
          end else begin
            eff_h_r <= cfg_data[COORD_W-1:0];
          end
        end
        REG_KEY_COLOR: begin
          key_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Command registers, loaded on the input transfer.
  logic [COORD_W-1:0] sr_r, sc_r, er_r, ec_r;
  logic               filled_r;
  logic               multi_r;
  logic [1:0]         kind_r;
  logic [COLOR_W-1:0] color_r;
  logic [COLOR_W-1:0] item_color;
  logic               rect_empty;
  logic [1:0]         load_kind;

  assign item_color = {item.red, item.green, item.blue};
  assign rect_empty = (item.start_row > item.end_row) || (item.start_col > item.end_col);

  always_comb begin
    unique case (item.action)
      ACT_RECT:    load_kind = rect_empty ? KIND_NONE : KIND_WRITE;
      ACT_PATTERN: load_kind = item.mask ? KIND_WRITE : KIND_NONE;
      ACT_IMAGE:   load_kind = (item_color != key_r) ? KIND_WRITE : KIND_NONE;
      ACT_READ:    load_kind = KIND_READ;
      default:     load_kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sr_r     <= item.start_row;
      sc_r     <= item.start_col;
      er_r     <= item.end_row;
      ec_r     <= item.end_col;
      filled_r <= item.filled;
      color_r  <= item_color;
      kind_r   <= load_kind;
      multi_r  <= (item.action == ACT_RECT) && !rect_empty;
    end
  end

  // Pixel walker: row-major over the rectangle, jumping across the interior
  // of an outline; overlay commands place one pixel at origin plus offset.
  logic [POS_W-1:0] row_r, col_r;
  logic [POS_W-1:0] row_nxt, col_nxt;
  logic             at_end_col;
  logic             skip_inner;

  assign at_end_col = (col_r == POS_W'(ec_r));
  assign skip_inner = !filled_r && (row_r != POS_W'(sr_r)) && (row_r != POS_W'(er_r))
                      && (col_r == POS_W'(sc_r));

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.load) begin
      if (item.action == ACT_PATTERN || item.action == ACT_IMAGE) begin
        row_nxt = POS_W'(item.start_row) + POS_W'(item.end_row);
        col_nxt = POS_W'(item.start_col) + POS_W'(item.end_col);
      end else begin
        row_nxt = POS_W'(item.start_row);
        col_nxt = POS_W'(item.start_col);
      end
    end else if (cmd.issue && multi_r) begin
      if (at_end_col) begin
        col_nxt = POS_W'(sc_r);
        row_nxt = row_r + POS_W'(1);
      end else if (skip_inner) begin
        col_nxt = POS_W'(ec_r);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

  assign stat.op_last = !multi_r || ((row_r == POS_W'(er_r)) && at_end_col);

  // Clipping test and row base product for the current pixel.
  logic               pix_inside;
  logic [COORD_W-1:0] row_m1, col_m1;
  logic [BASE_W-1:0]  base_prod;

  assign pix_inside = (row_r >= POS_W'(1)) && (row_r <= POS_W'(eff_h_r))
                      && (col_r >= POS_W'(1)) && (col_r <= POS_W'(eff_w_r));
  assign row_m1    = row_r[COORD_W-1:0] - COORD_W'(1);
  assign col_m1    = col_r[COORD_W-1:0] - COORD_W'(1);
  assign base_prod = BASE_W'(row_m1) * BASE_W'(eff_w_r);

  // Stage one: registered product, kind and clip result.
  logic               s1_v_r;
  logic               s1_last_r;
  logic [1:0]         s1_kind_r;
  logic               s1_inside_r;
  logic [BASE_W-1:0]  s1_base_r;
  logic [COORD_W-1:0] s1_colm1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_last_r   <= stat.op_last;
      s1_kind_r   <= kind_r;
      s1_inside_r <= pix_inside;
      s1_base_r   <= base_prod;
      s1_colm1_r  <= col_m1;
    end
  end

  // Clearing sweep address.
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign stat.clear_last = (clr_addr_r == AW'(DEPTH - 1));

  // Frame store access: the sweep during clearing, else stage one.
  logic [SUM_W-1:0]   s1_sum;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [COLOR_W-1:0] ram_rdata;

  assign s1_sum    = SUM_W'(s1_base_r) + SUM_W'(s1_colm1_r);
  assign ram_we    = cmd.clear || (s1_v_r && (s1_kind_r == KIND_WRITE) && s1_inside_r);
  assign ram_addr  = cmd.clear ? clr_addr_r : AW'(s1_sum);
  assign ram_wdata = cmd.clear ? '0 : color_r;

  fbde_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Status collects every addressed pixel that fell outside the image.
  logic status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
    end else if (cmd.load) begin
      status_r <= 1'b0;
    end else if (s1_v_r && (s1_kind_r != KIND_NONE) && !s1_inside_r) begin
      status_r <= 1'b1;
    end
  end

  // Stage two: the last operation of a command, with its read data arriving.
  logic s2_v_r;
  logic s2_read_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_read_ok_r <= (s1_kind_r == KIND_READ) && s1_inside_r;
    end
  end

  fbde_result_t new_res;

  always_comb begin
    new_res.read_red   = s2_read_ok_r ? ram_rdata[3*CHAN_W-1:2*CHAN_W] : '0;
    new_res.read_green = s2_read_ok_r ? ram_rdata[2*CHAN_W-1:CHAN_W] : '0;
    new_res.read_blue  = s2_read_ok_r ? ram_rdata[CHAN_W-1:0] : '0;
    new_res.status     = status_r;
  end

  assign stat.result_push = s2_v_r;

  // Two-entry result queue: head register and skid register.
  fbde_result_t head_r, skid_r;
  logic         head_v_r, skid_v_r;
  logic         head_v_nxt, skid_v_nxt;
  logic         head_ld_new, head_ld_skid, skid_ld;
  logic         push, pop;

  assign push = s2_v_r;
  assign pop  = head_v_r && out_ready;

  always_comb begin
    head_v_nxt   = head_v_r;
    skid_v_nxt   = skid_v_r;
    head_ld_new  = 1'b0;
    head_ld_skid = 1'b0;
    skid_ld      = 1'b0;
    if (!head_v_r) begin
      if (push) begin
        head_v_nxt  = 1'b1;
        head_ld_new = 1'b1;
      end
    end else if (!skid_v_r) begin
      if (pop && push) begin
        head_ld_new = 1'b1;
      end else if (pop) begin
        head_v_nxt = 1'b0;
      end else if (push) begin
        skid_v_nxt = 1'b1;
        skid_ld    = 1'b1;
      end
    end else if (pop) begin
      head_ld_skid = 1'b1;
      if (push) begin
        skid_ld = 1'b1;
      end else begin
        skid_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_ld_new) begin
      head_r <= new_res;
    end else if (head_ld_skid) begin
      head_r <= skid_r;
    end
    if (skid_ld) begin
      skid_r <= new_res;
    end
  end

  assign stat.queue_full = skid_v_r;
  assign out_valid       = head_v_r;
  assign result          = head_r;

endmodule

// File: rtl/fbde_checker.sv
// ----------------------------------------------------------------------------
// fbde_checker: port-level assertions for the frame buffer draw engine
// Watches the channel ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module fbde_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fbde_pkg::CHAN_W-1:0] out_read_red,
  input logic [fbde_pkg::CHAN_W-1:0] out_read_green,
  input logic [fbde_pkg::CHAN_W-1:0] out_read_blue,
  input logic                        out_status
);
  import fbde_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_red) && $stable(out_read_green)
      && $stable(out_read_blue) && $stable(out_status))
    else $error("result changed while stalled");

  // A flagged result never carries color: writes return zero, and so does
  // a read outside the image.
  a_status_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_read_red == '0) && (out_read_green == '0)
      && (out_read_blue == '0))
    else $error("flagged result carries color");

  // Commands are taken one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in flight");

  // The clearing sweep holds off commands right after reset.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("command port open before the frame store is cleared");

endmodule

bind frame_buffer_draw_engine fbde_checker u_fbde_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_red   (out_ch.read_red),
  .out_read_green (out_ch.read_green),
  .out_read_blue  (out_ch.read_blue),
  .out_status     (out_ch.status)
);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the frame buffer draw engine
// Drives drawing and read commands through the command channel and keeps its
// own copy of the frame store and registers. Each result is checked field by
// field against the predicted one. The run has a directed opening, several
// register settings with random commands, random stalls on both channels and
// repeated long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;
  import fbde_pkg::*;

  localparam int FB_COLS = 256;
  localparam int FB_ROWS = 256;
  localparam int STORE_DEPTH = FB_COLS * FB_ROWS;
  localparam int STALL_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 116;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbde_in_if in_ch ();
  fbde_out_if out_ch ();

  frame_buffer_draw_engine #(
    .MAX_COLS(FB_COLS),
    .MAX_ROWS(FB_ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the frame store and of the registers.
  logic [COLOR_W-1:0] frame_model [0:STORE_DEPTH-1];
  logic [COORD_W-1:0] cur_width;
  logic [COORD_W-1:0] cur_height;
  logic [COLOR_W-1:0] cur_key;

  fbde_item_t cmd_queue [$];
  fbde_result_t pending_results [$];
  fbde_result_t next_result;
  logic cmd_taken = 1'b0;
  logic steady_flow = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 120;

  int unsigned phase_widths [PHASES] = '{16, 1, 0, 511, 256, 37};
  int unsigned phase_heights [PHASES] = '{12, 1, 0, 300, 256, 200};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Width and height as the engine uses them: saturated to the store size.
  function automatic int unsigned eff_cols();
    if (cur_width == 0) return 1;
    if (cur_width > FB_COLS) return FB_COLS;
    return 32'(cur_width);
  endfunction

  function automatic int unsigned eff_rows();
    if (cur_height == 0) return 1;
    if (cur_height > FB_ROWS) return FB_ROWS;
    return 32'(cur_height);
  endfunction

  function automatic logic on_image(int unsigned row, int unsigned col);
    return row >= 1 && row <= eff_rows() && col >= 1 && col <= eff_cols();
  endfunction

  function automatic int unsigned pixel_index(int unsigned row, int unsigned col);
    return ((row - 1) * eff_cols() + (col - 1)) % STORE_DEPTH;
  endfunction

  // Writes one pixel of the shadow store; returns 1 when it was clipped.
  function automatic logic paint_pixel(int unsigned row, int unsigned col,
                                       logic [COLOR_W-1:0] color);
    if (!on_image(row, col)) return 1'b1;
    frame_model[pixel_index(row, col)] = color;
    return 1'b0;
  endfunction

  // Applies one command to the shadow store and returns its result.
  function automatic fbde_result_t apply_command(fbde_item_t c);
    fbde_result_t res;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] pixel;
    int unsigned r;
    int unsigned k;
    res = '0;
    color = {c.red, c.green, c.blue};
    case (c.action)
      ACT_RECT: begin
        if (c.start_row <= c.end_row && c.start_col <= c.end_col) begin
          for (r = 32'(c.start_row); r <= c.end_row; r++) begin
            for (k = 32'(c.start_col); k <= c.end_col; k++) begin
              if (c.filled || r == c.start_row || r == c.end_row ||
                  k == c.start_col || k == c.end_col) begin
                res.status |= paint_pixel(r, k, color);
              end
            end
          end
        end
      end
      ACT_PATTERN: begin
        if (c.mask) begin
          res.status = paint_pixel(32'(c.start_row) + 32'(c.end_row),
                                   32'(c.start_col) + 32'(c.end_col), color);
        end
      end
      ACT_IMAGE: begin
        if (color != cur_key) begin
          res.status = paint_pixel(32'(c.start_row) + 32'(c.end_row),
                                   32'(c.start_col) + 32'(c.end_col), color);
        end
      end
      default: begin
        if (on_image(32'(c.start_row), 32'(c.start_col))) begin
          pixel = frame_model[pixel_index(32'(c.start_row), 32'(c.start_col))];
          {res.read_red, res.read_green, res.read_blue} = pixel;
        end else begin
          res.status = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic fbde_item_t pack_command(logic [ACTION_W-1:0] act, int sr, int sc,
                                              int er, int ec, logic [COLOR_W-1:0] color,
                                              logic filled, logic mask);
    fbde_item_t c;
    c.action = act;
    c.start_row = COORD_W'(sr);
    c.start_col = COORD_W'(sc);
    c.end_row = COORD_W'(er);
    c.end_col = COORD_W'(ec);
    {c.red, c.green, c.blue} = color;
    c.filled = filled;
    c.mask = mask;
    return c;
  endfunction

  // Random command aimed at the image border so that clipping is exercised.
  function automatic fbde_item_t random_command();
    fbde_item_t c;
    int unsigned rows_lim;
    int unsigned cols_lim;
    int unsigned pick;
    int er;
    int ec;
    rows_lim = (eff_rows() + 2 > FB_ROWS) ? FB_ROWS : eff_rows() + 2;
    cols_lim = (eff_cols() + 2 > FB_COLS) ? FB_COLS : eff_cols() + 2;
    pick = $urandom_range(0, 99);
    {c.red, c.green, c.blue} = 24'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      {c.red, c.green, c.blue} = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    end
    c.filled = 1'($urandom_range(0, 1));
    c.mask = 1'($urandom_range(0, 1));
    c.start_row = COORD_W'($urandom_range(1, rows_lim));
    c.start_col = COORD_W'($urandom_range(1, cols_lim));
    if (pick < 30) begin
      // Small rectangles; a zero draw span makes an empty one.
      c.action = ACT_RECT;
      er = int'(c.start_row) + $urandom_range(0, 7) - 1;
      ec = int'(c.start_col) + $urandom_range(0, 7) - 1;
      c.end_row = COORD_W'((er > FB_ROWS) ? FB_ROWS : er);
      c.end_col = COORD_W'((ec > FB_COLS) ? FB_COLS : ec);
    end else if (pick < 80) begin
      c.action = (pick < 55) ? ACT_PATTERN : ACT_IMAGE;
      c.end_row = COORD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 256)
                                                         : $urandom_range(0, 3));
      c.end_col = COORD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 256)
                                                         : $urandom_range(0, 3));
      if (c.action == ACT_IMAGE && $urandom_range(0, 9) < 3) begin
        {c.red, c.green, c.blue} = cur_key;
      end
    end else begin
      c.action = ACT_READ;
      c.end_row = COORD_W'($urandom_range(0, 256));
      c.end_col = COORD_W'($urandom_range(0, 256));
    end
    return c;
  endfunction

  // Register write; the shadow copy follows at once since the engine is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: cur_width = value[COORD_W-1:0];
      REG_IMAGE_HEIGHT: cur_height = value[COORD_W-1:0];
      REG_KEY_COLOR: cur_key = value;
      default: ;
    endcase
  endtask

  task automatic drain_commands();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || pending_results.size() != 0);
  endtask

  // Command driver: holds an offered command until its transfer.
  always @(negedge clk) begin
    if (cmd_taken) cmd_queue.pop_front();
    if (in_ch.valid && !cmd_taken) begin
      in_ch.valid <= 1'b1;
    end else if (cmd_queue.size() != 0 && rst_n &&
                 (steady_flow || $urandom_range(0, 99) >= 23)) begin
      in_ch.valid <= 1'b1;
      in_ch.action <= cmd_queue[0].action;
      in_ch.start_row <= cmd_queue[0].start_row;
      in_ch.start_col <= cmd_queue[0].start_col;
      in_ch.end_row <= cmd_queue[0].end_row;
      in_ch.end_col <= cmd_queue[0].end_col;
      in_ch.red <= cmd_queue[0].red;
      in_ch.green <= cmd_queue[0].green;
      in_ch.blue <= cmd_queue[0].blue;
      in_ch.filled <= cmd_queue[0].filled;
      in_ch.mask <= cmd_queue[0].mask;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus an occasional long hold-off that
  // lets the output queue fill and back-pressure the command channel.
  always @(negedge clk) begin
    if (rst_n && hold_left == 0 && results_seen >= next_hold_at) begin
      hold_left = 90;
      next_hold_at = next_hold_at + 330;
    end
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 23);
    end
  end

  // Command monitor: predicts the result of each command transfer.
  always @(posedge clk) begin
    cmd_taken = in_ch.valid && in_ch.ready;
    if (cmd_taken) begin
      pending_results.push_back(apply_command({in_ch.action, in_ch.start_row,
                                               in_ch.start_col, in_ch.end_row,
                                               in_ch.end_col, in_ch.red, in_ch.green,
                                               in_ch.blue, in_ch.filled, in_ch.mask}));
    end
  end

  // Result monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: rgb=%h%h%h status=%b", out_ch.read_red,
                   out_ch.read_green, out_ch.read_blue, out_ch.status);
        end
      end else begin
        next_result = pending_results.pop_front();
        if (out_ch.read_red !== next_result.read_red ||
            out_ch.read_green !== next_result.read_green ||
            out_ch.read_blue !== next_result.read_blue ||
            out_ch.status !== next_result.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected rgb=%h%h%h status=%b, got rgb=%h%h%h status=%b",
                     results_seen, next_result.read_red, next_result.read_green,
                     next_result.read_blue, next_result.status, out_ch.read_red,
                     out_ch.read_green, out_ch.read_blue, out_ch.status);
          end
        end
      end
    end
  end

  // Watchdog: the clearing sweep and the largest rectangle fit well inside.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Stimulus: reset, a directed opening, then one random phase per setting.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_RECT;
    in_ch.start_row = '0;
    in_ch.start_col = '0;
    in_ch.end_row = '0;
    in_ch.end_col = '0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    in_ch.filled = 1'b0;
    in_ch.mask = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    foreach (frame_model[i]) frame_model[i] = '0;
    cur_width = 9'd256;
    cur_height = 9'd256;
    cur_key = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_IMAGE_WIDTH, 24'd256);
    write_reg(REG_IMAGE_HEIGHT, 24'd256);
    write_reg(REG_KEY_COLOR, 24'h000000);

    // Cleared store, fills, outlines, empty rectangles, clipped overlays,
    // masked and keyed pixels, and full-image rectangles.
    cmd_queue.push_back(pack_command(ACT_READ, 1, 1, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 256, 256, 256, 256, 24'hFFFFFF, 1'b1, 1'b1));
    cmd_queue.push_back(pack_command(ACT_RECT, 1, 1, 3, 4, 24'hFF0000, 1'b1, 1'b0));
    cmd_queue.push_back(pack_command(ACT_RECT, 2, 2, 6, 7, 24'h00FF00, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 4, 4, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 2, 2, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 3, 1, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_RECT, 5, 1, 4, 3, 24'hFFFFFF, 1'b1, 1'b0));
    cmd_queue.push_back(pack_command(ACT_RECT, 1, 9, 3, 8, 24'hFFFFFF, 1'b0, 1'b1));
    cmd_queue.push_back(pack_command(ACT_PATTERN, 10, 10, 0, 0, 24'h0000FF, 1'b0, 1'b1));
    cmd_queue.push_back(pack_command(ACT_PATTERN, 11, 11, 0, 0, 24'h0000FF, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_PATTERN, 256, 256, 1, 0, 24'h00FFFF, 1'b0, 1'b1));
    cmd_queue.push_back(pack_command(ACT_PATTERN, 200, 100, 256, 256, 24'h00FFFF, 1'b0, 1'b1));
    cmd_queue.push_back(pack_command(ACT_IMAGE, 12, 12, 0, 0, 24'h000000, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_IMAGE, 255, 254, 1, 2, 24'hFFFFFF, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 256, 256, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 10, 10, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_RECT, 1, 1, 256, 256, 24'hA5A5A5, 1'b1, 1'b0));
    cmd_queue.push_back(pack_command(ACT_RECT, 1, 1, 256, 256, 24'h5A5A5A, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 256, 1, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 128, 128, 0, 0, 24'h0, 1'b0, 1'b0));
    cmd_queue.push_back(pack_command(ACT_READ, 1, 256, 0, 0, 24'h0, 1'b0, 1'b0));
    drain_commands();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(phase_widths[p]));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(phase_heights[p]));
      write_reg(REG_KEY_COLOR, (p == 1) ? 24'hFFFFFF : 24'($urandom));
      // The full-size phase runs with no idling on either side.
      steady_flow = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) cmd_queue.push_back(random_command());
      drain_commands();
      steady_flow = 1'b0;
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
